// File: sv/lrfp_pkg.sv
// Shared types, widths and command codes for the fixed-point line rasterizer.
// Depends on nothing; every module of the block imports it.
package lrfp_pkg;

	localparam int COORD_BITS = 12;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_BITS   = 32;
	localparam int COLOR_BITS = 24;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int CNT_BITS   = $clog2(QUO_BITS);

	localparam int S_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS;
	localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
	localparam int M_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
	localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam logic [FRAC_BITS-1:0] HALF_UNIT = {1'b1, {(FRAC_BITS-1){1'b0}}};

	// One classified command as it waits in the queue.
	typedef struct packed {
		logic                         advance;
		logic                         major_is_y;
		logic signed [COORD_BITS-1:0] start_major;
		logic signed [COORD_BITS-1:0] start_minor;
		logic signed [DELTA_BITS-1:0] long_delta;
		logic signed [DELTA_BITS-1:0] short_delta;
		logic [COLOR_BITS-1:0]        color;
	} cmd_t;

	typedef struct packed {
		logic                         start;
		logic signed [DELTA_BITS-1:0] long_delta;
		logic signed [DELTA_BITS-1:0] short_delta;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [ACC_BITS-1:0] slope;
	} div_rsp_t;

endpackage

// File: sv/line_rasterizer_fixed_point.sv
// Fixed-point line rasterizer: start commands set up a line, advance commands emit pixels.
// An advance at the queue head is stepped into the output register when that is free.
// One pixel per cycle unless output stalls; advances wait out each start's 17-step divide.
// Reset (arst_n low, asynchronous) empties the queue, drops any line and the output pixel.
// Depends on lrfp_pkg, lrfp_front, lrfp_queue, lrfp_back and lrfp_div.
module line_rasterizer_fixed_point import lrfp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], line_color[71:48]
	input  logic [S_TDATA_BITS-1:0] s_tdata,
	// command[0]: 0 starts a new line, 1 advances one pixel
	input  logic                    s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// pixel_x[11:0], pixel_y[23:12], pixel_color[47:24]
	output logic [M_TDATA_BITS-1:0] m_tdata,
	// last_pixel
	output logic                    m_tlast
);

	// The front end classifies each transfer as it arrives: for a start it
	// forms both deltas, picks the major axis and splits the start point into
	// major and minor parts, so the queue holds commands ready to run.
	cmd_t front_cmd;
	cmd_t head_cmd;
	logic head_valid;
	logic queue_not_full;
	logic back_pop;

	lrfp_front u_front (
		.tdata (s_tdata),
		.tuser (s_tuser),
		.cmd   (front_cmd)
	);

	// The input side is ready whenever the queue has room, so commands keep
	// arriving while the back end divides or waits on the output side.
	assign s_tready = queue_not_full;

	lrfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.din       (front_cmd),
		.pop       (back_pop),
		.dout      (head_cmd),
		.not_empty (head_valid),
		.not_full  (queue_not_full)
	);

	// The back end runs commands in order. A start loads the line state and
	// the slope divider; advances wait until the slope is known and then step
	// one pixel each into the output register.
	lrfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_cmd),
		.head_valid (head_valid),
		.pop        (back_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// File: sv/lrfp_front.sv
// Front end: unpacks an input transfer and classifies it into a queue entry.
// A start gets its deltas, major axis and start point here. Uses lrfp_pkg.
module lrfp_front import lrfp_pkg::*; (
	input  logic [S_TDATA_BITS-1:0] tdata,
	input  logic                    tuser,
	output cmd_t                    cmd
);

	logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
	logic signed [DELTA_BITS-1:0] dx, dy;
	logic [DELTA_BITS-1:0]        adx, ady;
	logic                         swap;

	always_comb begin
		sx = tdata[0*COORD_BITS +: COORD_BITS];
		sy = tdata[1*COORD_BITS +: COORD_BITS];
		ex = tdata[2*COORD_BITS +: COORD_BITS];
		ey = tdata[3*COORD_BITS +: COORD_BITS];
		dx = DELTA_BITS'(ex) - DELTA_BITS'(sx);
		dy = DELTA_BITS'(ey) - DELTA_BITS'(sy);
		adx = dx[DELTA_BITS-1] ? DELTA_BITS'(-dx) : DELTA_BITS'(dx);
		ady = dy[DELTA_BITS-1] ? DELTA_BITS'(-dy) : DELTA_BITS'(dy);
		// y becomes the major axis only when it is strictly longer.
		swap = ady > adx;

		cmd.advance     = (tuser == CMD_ADVANCE);
		cmd.major_is_y  = swap;
		cmd.start_major = swap ? sy : sx;
		cmd.start_minor = swap ? sx : sy;
		cmd.long_delta  = swap ? dy : dx;
		cmd.short_delta = swap ? dx : dy;
		cmd.color       = tdata[4*COORD_BITS +: COLOR_BITS];
	end

endmodule

// File: sv/lrfp_queue.sv
// Small command queue between the front end and the back end.
// Registers only, combinational head read. Uses lrfp_pkg.
module lrfp_queue import lrfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic not_empty,
	output logic not_full
);

	cmd_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign not_empty = (count_q != '0);
	assign not_full  = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign dout      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && not_full) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && not_full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push && not_full, pop && not_empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/lrfp_div.sv
// Radix-2 restoring divider for the 16.16 slope, one quotient bit a cycle.
// Gives (short << 16) / long truncated toward zero, or 0 for a zero long delta.
module lrfp_div import lrfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [COORD_BITS:0]   rem_q;
	logic [COORD_BITS-1:0] den_q;
	logic [QUO_BITS-1:0]   quo_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q, neg_q, zero_q, done_q;
	logic [ACC_BITS-1:0]   slope_q;

	logic [DELTA_BITS-1:0] long_mag, short_mag;
	logic [COORD_BITS+1:0] diff;
	logic                  fits;
	logic [QUO_BITS-1:0]   quo_next;
	logic [ACC_BITS-1:0]   mag_ext;

	always_comb begin
		long_mag  = req.long_delta[DELTA_BITS-1] ? DELTA_BITS'(-req.long_delta)
		                                         : DELTA_BITS'(req.long_delta);
		short_mag = req.short_delta[DELTA_BITS-1] ? DELTA_BITS'(-req.short_delta)
		                                          : DELTA_BITS'(req.short_delta);
		diff      = {1'b0, rem_q} - {2'b00, den_q};
		fits      = !diff[COORD_BITS+1];
		quo_next  = {quo_q[QUO_BITS-2:0], fits};
		mag_ext   = {{(ACC_BITS-QUO_BITS){1'b0}}, quo_next};
	end

	assign rsp.done  = done_q;
	assign rsp.slope = slope_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= long_mag[COORD_BITS-1:0];
			rem_q <= {1'b0, short_mag[COORD_BITS-1:0]};
			quo_q <= '0;
			neg_q <= req.long_delta[DELTA_BITS-1] ^ req.short_delta[DELTA_BITS-1];
			zero_q <= (req.long_delta == '0);
		end else if (busy_q) begin
			// The remainder stays below the divisor, so its double fits.
			rem_q <= fits ? {diff[COORD_BITS-1:0], 1'b0} : {rem_q[COORD_BITS-1:0], 1'b0};
			quo_q <= quo_next;
		end
		if (busy_q && cnt_q == '0) begin
			slope_q <= zero_q ? '0 : (neg_q ? ACC_BITS'(-mag_ext) : mag_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == '0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QUO_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: sv/lrfp_back.sv
// Back end: runs the queued commands, holds the line state and the output register.
// Uses lrfp_pkg and the slope divider lrfp_div.
module lrfp_back import lrfp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    head,
	input  logic                    head_valid,
	output logic                    pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata,
	output logic                    m_tlast
);

	localparam logic ST_RUN = 1'b0;
	localparam logic ST_DIV = 1'b1;

	logic                         state_q;
	logic                         line_active_q, major_is_y_q, step_down_q;
	logic signed [DELTA_BITS-1:0] major_pos_q, major_final_q;
	logic [ACC_BITS-1:0]          acc_q, slope_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic                         tvalid_q, tlast_q;
	logic [M_TDATA_BITS-1:0]      tdata_q;

	div_req_t              div_req;
	div_rsp_t              div_rsp;
	logic                  take_start, emit, out_free, last;
	logic [COORD_BITS-1:0] maj, mnr;

	lrfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		out_free   = !tvalid_q || m_tready;
		take_start = head_valid && state_q == ST_RUN && !head.advance;
		emit       = head_valid && state_q == ST_RUN && head.advance && line_active_q
		             && out_free;
		// An advance with no line in progress is dropped without a pixel.
		pop        = take_start || emit
		             || (head_valid && state_q == ST_RUN && head.advance && !line_active_q);
		last       = (major_pos_q == major_final_q);
		maj        = major_pos_q[COORD_BITS-1:0];
		mnr        = acc_q[FRAC_BITS +: COORD_BITS];

		div_req.start       = take_start;
		div_req.long_delta  = head.long_delta;
		div_req.short_delta = head.short_delta;
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	always_ff @(posedge clk) begin
		if (take_start) begin
			major_is_y_q  <= head.major_is_y;
			step_down_q   <= !(head.long_delta > 0);
			major_pos_q   <= DELTA_BITS'(head.start_major);
			major_final_q <= DELTA_BITS'(head.start_major) + head.long_delta;
			acc_q         <= {{(ACC_BITS-FRAC_BITS-COORD_BITS){head.start_minor[COORD_BITS-1]}},
			                  head.start_minor, HALF_UNIT};
			color_q       <= head.color;
		end else if (emit) begin
			if (step_down_q) begin
				acc_q       <= acc_q - slope_q;
				major_pos_q <= major_pos_q - 1'b1;
			end else begin
				acc_q       <= acc_q + slope_q;
				major_pos_q <= major_pos_q + 1'b1;
			end
		end
		if (div_rsp.done) begin
			slope_q <= div_rsp.slope;
		end
		if (emit) begin
			tdata_q <= M_TDATA_BITS'({color_q, major_is_y_q ? maj : mnr,
			                          major_is_y_q ? mnr : maj});
			tlast_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_RUN;
			line_active_q <= 1'b0;
			tvalid_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (take_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
			if (take_start) begin
				line_active_q <= 1'b1;
			end else if (emit && last) begin
				line_active_q <= 1'b0;
			end
			if (emit) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/lrfp_chk.sv
// Port-level checker for the line rasterizer, bound to the top level.
// Uses lrfp_pkg for the port widths.
module lrfp_chk import lrfp_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic [S_TDATA_BITS-1:0] s_tdata,
	input logic                    s_tuser,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [M_TDATA_BITS-1:0] m_tdata,
	input logic                    m_tlast
);

	// A stalled pixel stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("pixel withdrawn while stalled");

	// A stalled pixel keeps its contents.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("pixel changed while stalled");

	// The queue only fills from input transfers.
	a_ready_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("input side became busy without a transfer");

	// Once reset has been seen at an edge, the input side is ready and no pixel is pending.
	a_reset_state: assert property (@(posedge clk)
		!arst_n |=> s_tready && !m_tvalid)
		else $error("reset left work pending");

endmodule

bind line_rasterizer_fixed_point lrfp_chk u_chk (.*);
